### rtl/czs_pkg.sv
// Shared types, constants and helpers for the CoreXY and Z stage step controller.
package czs_pkg;

  // Width of the stored positions and goals; they wrap in two's complement.
  localparam int POS_WIDTH = 32;

  // Width of the reported position fields.
  localparam int POS_OUT_WIDTH = 32;

  // Configuration register indexes (the value of address bit 2 on the configuration port).
  localparam logic REG_XY_INTERVAL = 1'b0;
  localparam logic REG_Z_INTERVAL  = 1'b1;

  // Reset values of the step intervals in milliseconds.
  localparam logic [15:0] INTERVAL_RESET = 16'd15;

  // Touch panel thresholds.
  localparam logic [9:0] PRESS_MIN   = 10'd10;
  localparam logic [9:0] Y_LOW_EDGE  = 10'd400;
  localparam logic [9:0] X_RIGHT     = 10'd600;
  localparam logic [9:0] Y_HIGH_EDGE = 10'd700;
  localparam logic [9:0] X_MID_LO    = 10'd380;
  localparam logic [9:0] X_MID_HI    = 10'd700;
  localparam logic [9:0] X_FAR_RIGHT = 10'd750;
  localparam logic [9:0] Y_BAND_LO   = 10'd450;
  localparam logic [9:0] Y_BAND_HI   = 10'd650;
  localparam logic [9:0] X_LEFT      = 10'd310;
  localparam logic [9:0] Y_SPLIT     = 10'd500;

  // Command codes carried in the input beat's tuser.
  typedef enum logic {
    CMD_LOOP = 1'b0,
    CMD_MOVE = 1'b1
  } cmd_t;

  // Axis selector of a move command.
  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  // Step codes reported for each motor group.
  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_FWD  = 2'd1,
    STEP_BWD  = 2'd2,
    STEP_BAD  = 2'd3
  } step_t;

  // Input beat payload, last field in the lowest bits.
  typedef struct packed {
    logic [5:0]  pad;
    logic        lower_limit_level;
    logic        upper_limit_level;
    logic [9:0]  touch_pressure;
    logic [9:0]  touch_y;
    logic [9:0]  touch_x;
    logic [31:0] now_ms;
    logic [31:0] steps;
    logic [1:0]  axis;
  } in_beat_t;

  // Result beat payload, last field in the lowest bits.
  typedef struct packed {
    logic [1:0]  pad;
    logic [31:0] z_position;
    logic [31:0] y_position;
    logic [31:0] x_position;
    logic [1:0]  z_step;
    logic [1:0]  belt_b_step;
    logic [1:0]  belt_a_step;
  } out_beat_t;

  localparam int IN_TDATA_W  = $bits(in_beat_t);
  localparam int OUT_TDATA_W = $bits(out_beat_t);

  typedef logic [POS_WIDTH-1:0] pos_t;

  // Sign-extend or cut a stored position to the reported width.
  function automatic logic [POS_OUT_WIDTH-1:0] pos_out(input pos_t p);
    logic signed [POS_WIDTH-1:0] ps;
    ps = signed'(p);
    return POS_OUT_WIDTH'(ps);
  endfunction

endpackage

### rtl/corexy_z_stage_step_controller.sv
// Top level of the CoreXY belt and Z motor pair step controller.
//
// The controller accepts one beat per clock cycle while results drain and returns exactly
// one result beat for each: an input register captures the beat, and a
// single pass of comparisons, one subtractor per axis and per timer, and one increment
// per axis loads the result register and the position state together, so the next beat
// sees the updated state without a wait. The result register and the input register
// each hold one beat, so input is taken while a result waits. A loop pass (tuser 0)
// applies the touch press, clears Z motion into a pressed limit switch and issues at
// most one step per motor group once its interval in milliseconds has strictly been
// exceeded; a move (tuser 1) adds a signed count to one axis and reports no step.
// The two step intervals sit at configuration byte addresses 0 and 4 and reset to 15.
module corexy_z_stage_step_controller
  import czs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input beats.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // axis[1:0], steps[33:2], now_ms[65:34], touch_x[75:66], touch_y[85:76],
  // touch_pressure[95:86], upper_limit_level[96], lower_limit_level[97], zeros above.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd[0].
  input  logic                   in_tuser,
  // Result beats.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // belt_a_step[1:0], belt_b_step[3:2], z_step[5:4], x_position[37:6],
  // y_position[69:38], z_position[101:70], zeros above.
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration port.
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  // Configuration registers.
  logic [15:0] xy_interval_r;
  logic [15:0] z_interval_r;
  logic        cfg_wr;

  // Input register.
  logic        s1_valid_r;
  cmd_t        s1_cmd_r;
  in_beat_t    s1_beat_r;

  // Position state.
  pos_t        x_now_r, y_now_r, z_now_r;
  pos_t        x_goal_r, y_goal_r, z_goal_r;
  logic [31:0] xy_last_r, z_last_r;
  pos_t        x_now_nxt, y_now_nxt, z_now_nxt;
  pos_t        x_goal_nxt, y_goal_nxt, z_goal_nxt;
  logic [31:0] xy_last_nxt, z_last_nxt;

  // Result register.
  logic        out_valid_r;
  out_beat_t   out_beat_r;
  out_beat_t   out_beat_nxt;

  logic        advance;

  // Distance and timing terms.
  pos_t        dx_raw, dy_raw, dz_raw;
  logic        x_pos, x_neg, y_pos, y_neg, z_pos, z_neg;
  logic        pressed;
  logic        t_y_dec, t_y_inc, t_x_inc, t_x_dec, t_z_inc, t_z_dec;
  logic [31:0] xy_elapsed, z_elapsed;
  logic        xy_due, z_due;
  step_t       a_code, b_code, z_code;
  pos_t        move_sum_x, move_sum_y, move_sum_z;
  pos_t        steps_ext;

  // Configuration port: writes land on the access cycle, reads return the register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xy_interval_r <= INTERVAL_RESET;
      z_interval_r  <= INTERVAL_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_XY_INTERVAL) begin
        xy_interval_r <= cfg_pwdata[15:0];
      end else begin
        z_interval_r <= cfg_pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_XY_INTERVAL) begin
      cfg_prdata = {16'd0, xy_interval_r};
    end else begin
      cfg_prdata = {16'd0, z_interval_r};
    end
  end

  // Handshake: the input register moves on when the result register is free or drains.
  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= cmd_t'(in_tuser);
      s1_beat_r <= in_beat_t'(in_tdata);
    end
  end

  // Distance signs from the stored goals.
  assign dx_raw = x_goal_r - x_now_r;
  assign dy_raw = y_goal_r - y_now_r;
  assign dz_raw = z_goal_r - z_now_r;

  // Touch sectors.
  always_comb begin
    pressed = s1_beat_r.touch_pressure > PRESS_MIN;
    t_y_dec = pressed && (s1_beat_r.touch_y < Y_LOW_EDGE) && (s1_beat_r.touch_x > X_RIGHT);
    t_y_inc = pressed && (s1_beat_r.touch_y > Y_HIGH_EDGE) && (s1_beat_r.touch_x > X_RIGHT);
    t_x_inc = pressed && (s1_beat_r.touch_x < X_MID_HI) && (s1_beat_r.touch_x > X_MID_LO)
              && (s1_beat_r.touch_y > Y_BAND_LO) && (s1_beat_r.touch_y < Y_BAND_HI);
    t_x_dec = pressed && (s1_beat_r.touch_x > X_FAR_RIGHT)
              && (s1_beat_r.touch_y > Y_BAND_LO) && (s1_beat_r.touch_y < Y_BAND_HI);
    t_z_inc = pressed && (s1_beat_r.touch_x < X_LEFT) && (s1_beat_r.touch_y < Y_SPLIT);
    t_z_dec = pressed && (s1_beat_r.touch_x < X_LEFT) && (s1_beat_r.touch_y > Y_SPLIT);
  end

  // Interval timers, unsigned wrapping difference.
  assign xy_elapsed = s1_beat_r.now_ms - xy_last_r;
  assign z_elapsed  = s1_beat_r.now_ms - z_last_r;
  assign xy_due     = xy_elapsed > {16'd0, xy_interval_r};
  assign z_due      = z_elapsed > {16'd0, z_interval_r};

  // Move command sums.
  assign steps_ext  = POS_WIDTH'(signed'(s1_beat_r.steps));
  assign move_sum_x = x_now_r + steps_ext;
  assign move_sum_y = y_now_r + steps_ext;
  assign move_sum_z = z_now_r + steps_ext;

  // One pass over the item: goals, limits, then the Z and XY steps.
  always_comb begin
    x_now_nxt   = x_now_r;
    y_now_nxt   = y_now_r;
    z_now_nxt   = z_now_r;
    x_goal_nxt  = x_goal_r;
    y_goal_nxt  = y_goal_r;
    z_goal_nxt  = z_goal_r;
    xy_last_nxt = xy_last_r;
    z_last_nxt  = z_last_r;
    a_code      = STEP_NONE;
    b_code      = STEP_NONE;
    z_code      = STEP_NONE;

    x_pos = (dx_raw != '0) && !dx_raw[POS_WIDTH-1];
    x_neg = dx_raw[POS_WIDTH-1];
    y_pos = (dy_raw != '0) && !dy_raw[POS_WIDTH-1];
    y_neg = dy_raw[POS_WIDTH-1];
    z_pos = (dz_raw != '0) && !dz_raw[POS_WIDTH-1];
    z_neg = dz_raw[POS_WIDTH-1];

    if (s1_cmd_r == CMD_MOVE) begin
      case (axis_t'(s1_beat_r.axis))
        AXIS_X:  x_goal_nxt = move_sum_x;
        AXIS_Y:  y_goal_nxt = move_sum_y;
        AXIS_Z:  z_goal_nxt = move_sum_z;
        default: ;
      endcase
    end else begin
      // A touch goal sits one step away, so its sign is known directly.
      if (t_y_dec) begin
        y_goal_nxt = y_now_r - POS_WIDTH'(1);
        y_pos = 1'b0;
        y_neg = 1'b1;
      end
      if (t_y_inc) begin
        y_goal_nxt = y_now_r + POS_WIDTH'(1);
        y_pos = 1'b1;
        y_neg = 1'b0;
      end
      if (t_x_inc) begin
        x_goal_nxt = x_now_r + POS_WIDTH'(1);
        x_pos = 1'b1;
        x_neg = 1'b0;
      end
      if (t_x_dec) begin
        x_goal_nxt = x_now_r - POS_WIDTH'(1);
        x_pos = 1'b0;
        x_neg = 1'b1;
      end
      if (t_z_inc) begin
        z_goal_nxt = z_now_r + POS_WIDTH'(1);
        z_pos = 1'b1;
        z_neg = 1'b0;
      end
      if (t_z_dec) begin
        z_goal_nxt = z_now_r - POS_WIDTH'(1);
        z_pos = 1'b0;
        z_neg = 1'b1;
      end

      // A pressed limit switch cancels Z motion toward it.
      if ((!s1_beat_r.upper_limit_level && z_pos) || (!s1_beat_r.lower_limit_level && z_neg))
      begin
        z_goal_nxt = z_now_r;
        z_pos = 1'b0;
        z_neg = 1'b0;
      end

      // Z group step.
      if (z_due && (z_pos || z_neg)) begin
        z_last_nxt = s1_beat_r.now_ms;
        if (z_pos) begin
          z_code    = STEP_FWD;
          z_now_nxt = z_now_r + POS_WIDTH'(1);
        end else begin
          z_code    = STEP_BWD;
          z_now_nxt = z_now_r - POS_WIDTH'(1);
        end
      end

      // XY group step, CoreXY belt mapping.
      if (xy_due && (x_pos || x_neg || y_pos || y_neg)) begin
        xy_last_nxt = s1_beat_r.now_ms;
        if (x_pos && y_pos) begin
          a_code = STEP_FWD;
        end else if (x_pos && y_neg) begin
          b_code = STEP_FWD;
        end else if (x_neg && y_pos) begin
          b_code = STEP_BWD;
        end else if (x_neg && y_neg) begin
          a_code = STEP_BWD;
        end else if (y_pos) begin
          a_code = STEP_FWD;
          b_code = STEP_BWD;
        end else if (y_neg) begin
          a_code = STEP_BWD;
          b_code = STEP_FWD;
        end else if (x_pos) begin
          a_code = STEP_FWD;
          b_code = STEP_FWD;
        end else begin
          a_code = STEP_BWD;
          b_code = STEP_BWD;
        end
        if (x_pos) begin
          x_now_nxt = x_now_r + POS_WIDTH'(1);
        end else if (x_neg) begin
          x_now_nxt = x_now_r - POS_WIDTH'(1);
        end
        if (y_pos) begin
          y_now_nxt = y_now_r + POS_WIDTH'(1);
        end else if (y_neg) begin
          y_now_nxt = y_now_r - POS_WIDTH'(1);
        end
      end
    end

    out_beat_nxt             = '0;
    out_beat_nxt.belt_a_step = a_code;
    out_beat_nxt.belt_b_step = b_code;
    out_beat_nxt.z_step      = z_code;
    out_beat_nxt.x_position  = pos_out(x_now_nxt);
    out_beat_nxt.y_position  = pos_out(y_now_nxt);
    out_beat_nxt.z_position  = pos_out(z_now_nxt);
  end

  // State update on each processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_now_r   <= '0;
      y_now_r   <= '0;
      z_now_r   <= '0;
      x_goal_r  <= '0;
      y_goal_r  <= '0;
      z_goal_r  <= '0;
      xy_last_r <= '0;
      z_last_r  <= '0;
    end else if (advance) begin
      x_now_r   <= x_now_nxt;
      y_now_r   <= y_now_nxt;
      z_now_r   <= z_now_nxt;
      x_goal_r  <= x_goal_nxt;
      y_goal_r  <= y_goal_nxt;
      z_goal_r  <= z_goal_nxt;
      xy_last_r <= xy_last_nxt;
      z_last_r  <= z_last_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_beat_r <= out_beat_nxt;
    end
  end

endmodule

### rtl/czs_checker.sv
// Port-level assertions for the step controller, bound to the top level.
module czs_checker
  import czs_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // No motor group ever reports the unused step code.
  a_step_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != STEP_BAD && out_tdata[3:2] != STEP_BAD
                   && out_tdata[5:4] != STEP_BAD)
    else $error("illegal step code");

  // With both buffers empty and no beat arriving, nothing appears next cycle.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && in_tready && !in_tvalid && $past(in_tready && !in_tvalid)
    && $past(!out_tvalid) |=> !out_tvalid)
    else $error("result beat without an input beat");

endmodule

bind corexy_z_stage_step_controller czs_checker u_czs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
